// ----- rtl/cmtm_pkg.sv -----
// ----------------------------------------------------------------------------
// cmtm_pkg
// Shared types, constants and helpers of the CAN receive mailbox timeout
// monitor.
// ----------------------------------------------------------------------------
package cmtm_pkg;

  localparam int MAX_SLOTS    = 8;
  localparam int ENTRIES_DEF  = 8;
  localparam int TIMEOUT_DEF  = 2000;
  localparam int ID_W         = 29;
  localparam int DATA_W       = 64;
  localparam int LEN_W        = 4;
  localparam int CFG_IDX_W    = $clog2(MAX_SLOTS);
  localparam int REQ_W        = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // per-entry command for one transfer
  typedef struct packed {
    logic is_frame;
    logic is_tick;
    logic clr_new;
  } entry_ctl_t;

  // per-entry status
  typedef struct packed {
    logic match;
    logic timed_out;
    logic timed_out_next;
    logic has_new;
  } entry_st_t;

  // byte-lane write mask for a DLC, clamped to eight bytes
  function automatic logic [DATA_W-1:0] keep_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    logic [DATA_W-1:0] m;
    n = (len > LEN_W'(8)) ? LEN_W'(8) : len;
    for (int j = 0; j < DATA_W / 8; j++) begin
      m[8*j +: 8] = (LEN_W'(j) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- rtl/can_rx_mailbox_timeout_monitor.sv -----
// ----------------------------------------------------------------------------
// can_rx_mailbox_timeout_monitor
// Supervises up to eight expected CAN receive IDs: payload capture on match,
// millisecond silence timers with timeout flags, and entry read-back.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  --------------------------------------
//  request   start & !busy             req_type, frame_id, frame_len,
//                                      frame_data, entry_index, clear_new
//  result    done (one-cycle strobe)   match_mask, timeout_mask, entry_payload,
//                                      entry_timed_out, entry_has_new
//  config    cfg_we                    cfg_index, cfg_data
//
//  - One request transfer per cycle; busy is never raised.
//  - An item passes the request register, then the entry update and the
//    result register in the same cycle; the result register drives done.
//  - Items update entry state in accept order, so back-to-back items see
//    each other's effects.
//  - rst is synchronous: clears IDs, timers, flags and payloads at once.
//  - done marks each result for one cycle only; the receiver cannot stall it.
//
module can_rx_mailbox_timeout_monitor #(
  parameter int ENTRIES       = cmtm_pkg::ENTRIES_DEF,
  parameter int TIMEOUT_TICKS = cmtm_pkg::TIMEOUT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cmtm_pkg::REQ_W-1:0]      req_type,
  input  logic [cmtm_pkg::ID_W-1:0]       frame_id,
  input  logic [cmtm_pkg::LEN_W-1:0]      frame_len,
  input  logic [cmtm_pkg::DATA_W-1:0]     frame_data,
  input  logic [cmtm_pkg::CFG_IDX_W-1:0]  entry_index,
  input  logic                            clear_new,
  input  logic                            cfg_we,
  input  logic [cmtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmtm_pkg::ID_W-1:0]       cfg_data,
  output logic                            done,
  output logic [cmtm_pkg::MAX_SLOTS-1:0]  match_mask,
  output logic [cmtm_pkg::MAX_SLOTS-1:0]  timeout_mask,
  output logic [cmtm_pkg::DATA_W-1:0]     entry_payload,
  output logic                            entry_timed_out,
  output logic                            entry_has_new
);

  // Request register
  logic                            req_vld;
  logic [cmtm_pkg::REQ_W-1:0]      req_q;
  logic [cmtm_pkg::ID_W-1:0]       fid_q;
  logic [cmtm_pkg::LEN_W-1:0]      len_q;
  logic [cmtm_pkg::DATA_W-1:0]     data_q;
  logic [cmtm_pkg::CFG_IDX_W-1:0]  idx_q;
  logic                            clr_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q  <= req_type;
      fid_q  <= frame_id;
      len_q  <= frame_len;
      data_q <= frame_data;
      idx_q  <= entry_index;
      clr_q  <= clear_new;
    end
  end

  // Decode
  logic is_frame, is_tick, is_read, rd_ok;
  logic [cmtm_pkg::DATA_W-1:0] keep;

  always_comb begin
    is_frame = 1'b0;
    is_tick  = 1'b0;
    is_read  = 1'b0;
    case (cmtm_pkg::req_t'(req_q))
      cmtm_pkg::REQ_FRAME: is_frame = req_vld;
      cmtm_pkg::REQ_TICK:  is_tick  = req_vld;
      cmtm_pkg::REQ_READ:  is_read  = req_vld;
      default: ;  // unused code: state untouched
    endcase
  end

  // reads beyond the active entries return zeros and clear nothing
  assign rd_ok = is_read && ({1'b0, idx_q} < (cmtm_pkg::CFG_IDX_W + 1)'(ENTRIES));
  assign keep  = cmtm_pkg::keep_mask(len_q);

  // Entries
  cmtm_pkg::entry_st_t          st  [ENTRIES];
  logic [cmtm_pkg::DATA_W-1:0]  pay [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
    cmtm_pkg::entry_ctl_t ctl;
    logic sel;

    assign sel          = (idx_q == cmtm_pkg::CFG_IDX_W'(g));
    assign ctl.is_frame = is_frame;
    assign ctl.is_tick  = is_tick;
    assign ctl.clr_new  = rd_ok && sel && clr_q;

    cmtm_entry #(
      .TIMEOUT_TICKS(TIMEOUT_TICKS)
    ) u_entry (
      .clk       (clk),
      .rst       (rst),
      .cfg_we    (cfg_we && (cfg_index == cmtm_pkg::CFG_IDX_W'(g))),
      .cfg_data  (cfg_data),
      .ctl       (ctl),
      .frame_id  (fid_q),
      .frame_data(data_q),
      .keep      (keep),
      .st        (st[g]),
      .payload   (pay[g])
    );
  end

  // Result assembly: masks reflect state after the item, read fields before
  logic [cmtm_pkg::MAX_SLOTS-1:0]  mm, tm;
  logic [cmtm_pkg::DATA_W-1:0]     rd_pay;
  logic                            rd_to, rd_new;

  always_comb begin
    mm     = '0;
    tm     = '0;
    rd_pay = '0;
    rd_to  = 1'b0;
    rd_new = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      mm[i] = st[i].match;
      tm[i] = st[i].timed_out_next;
      if (rd_ok && (idx_q == cmtm_pkg::CFG_IDX_W'(i))) begin
        rd_pay = pay[i];
        rd_to  = st[i].timed_out;
        rd_new = st[i].has_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      match_mask      <= mm;
      timeout_mask    <= tm;
      entry_payload   <= rd_pay;
      entry_timed_out <= rd_to;
      entry_has_new   <= rd_new;
    end
  end

endmodule

// ----- rtl/cmtm_entry.sv -----
// ----------------------------------------------------------------------------
// cmtm_entry
// One supervised mailbox: expected ID, silence timer, flags and payload.
// ----------------------------------------------------------------------------
module cmtm_entry #(
  parameter int TIMEOUT_TICKS = cmtm_pkg::TIMEOUT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cmtm_pkg::ID_W-1:0]  cfg_data,
  input  cmtm_pkg::entry_ctl_t       ctl,
  input  logic [cmtm_pkg::ID_W-1:0]  frame_id,
  input  logic [cmtm_pkg::DATA_W-1:0] frame_data,
  input  logic [cmtm_pkg::DATA_W-1:0] keep,
  output cmtm_pkg::entry_st_t        st,
  output logic [cmtm_pkg::DATA_W-1:0] payload
);

  localparam int TW = $clog2(TIMEOUT_TICKS + 1);
  localparam logic [TW-1:0] TO_MAX = TW'(TIMEOUT_TICKS);
  localparam logic [TW-1:0] TO_M1  = TW'(TIMEOUT_TICKS - 1);

  logic [cmtm_pkg::ID_W-1:0]   id;
  logic [TW-1:0]               timer, timer_next;
  logic                        timed_out, timed_out_next;
  logic                        has_new, has_new_next;
  logic [cmtm_pkg::DATA_W-1:0] payload_next;
  logic                        hit;

  assign hit = ctl.is_frame && (id == frame_id);

  always_comb begin
    timer_next     = timer;
    timed_out_next = timed_out;
    has_new_next   = has_new;
    payload_next   = payload;
    if (hit) begin
      timer_next     = '0;
      timed_out_next = 1'b0;
      has_new_next   = 1'b1;
      payload_next   = (payload & ~keep) | (frame_data & keep);
    end else if (ctl.is_tick) begin
      if (timer >= TO_M1) begin
        timer_next     = TO_MAX;
        timed_out_next = 1'b1;
      end else begin
        timer_next = timer + TW'(1);
      end
    end
    if (ctl.clr_new) begin
      has_new_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id        <= '0;
      timer     <= '0;
      timed_out <= 1'b0;
      has_new   <= 1'b0;
      payload   <= '0;
    end else begin
      if (cfg_we) begin
        id <= cfg_data;
      end
      timer     <= timer_next;
      timed_out <= timed_out_next;
      has_new   <= has_new_next;
      payload   <= payload_next;
    end
  end

  assign st.match          = hit;
  assign st.timed_out      = timed_out;
  assign st.timed_out_next = timed_out_next;
  assign st.has_new        = has_new;

endmodule

// ----- rtl/cmtm_checker.sv -----
// ----------------------------------------------------------------------------
// cmtm_checker
// Port-level checks of the mailbox timeout monitor, bound to the top level.
// ----------------------------------------------------------------------------
module cmtm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [cmtm_pkg::REQ_W-1:0]      req_type,
  input logic                            done,
  input logic [cmtm_pkg::MAX_SLOTS-1:0]  match_mask,
  input logic [cmtm_pkg::MAX_SLOTS-1:0]  timeout_mask,
  input logic [cmtm_pkg::DATA_W-1:0]     entry_payload,
  input logic                            entry_timed_out,
  input logic                            entry_has_new
);

  logic acc;
  assign acc = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##2 done)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !acc |-> ##2 !done)
    else $error("result without accepted item");

  a_mask_only_frame: assert property (@(posedge clk) disable iff (rst)
    (acc && req_type != cmtm_pkg::REQ_FRAME) |-> ##2 (match_mask == '0))
    else $error("match_mask set for a non-frame item");

  a_read_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (acc && req_type != cmtm_pkg::REQ_READ) |-> ##2
      (entry_payload == '0 && !entry_timed_out && !entry_has_new))
    else $error("read fields set for a non-read item");

  a_match_clears_timeout: assert property (@(posedge clk) disable iff (rst)
    (acc && req_type == cmtm_pkg::REQ_FRAME) |-> ##2
      ((match_mask & timeout_mask) == '0))
    else $error("matched entry still timed out");

endmodule

bind can_rx_mailbox_timeout_monitor cmtm_checker u_cmtm_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .req_type       (req_type),
  .done           (done),
  .match_mask     (match_mask),
  .timeout_mask   (timeout_mask),
  .entry_payload  (entry_payload),
  .entry_timed_out(entry_timed_out),
  .entry_has_new  (entry_has_new)
);
